### design/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants of the heapsort record sorter: record layout,
// controller states, datapath operation codes and status bundle.
// ----------------------------------------------------------------------------
package hsd_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int KEY_W = 14;
	localparam int TAG_W = 32;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} rec_t;

	// controller states
	typedef enum logic [3:0] {
		S_LOAD,
		S_BUILD_NEXT,
		S_BUILD_RD,
		S_BUILD_LD,
		S_EXT_NEXT,
		S_EXT_RD,
		S_EXT_LD,
		S_SIFT_RD,
		S_SIFT_CMP,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_HOLD
	} st_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_EXT_INIT,
		OP_EMIT_INIT,
		OP_BUILD_RD,
		OP_BUILD_LD,
		OP_EXT_RD,
		OP_EXT_LD,
		OP_SIFT_RD,
		OP_SIFT_CMP,
		OP_EMIT_RD,
		OP_EMIT_LD,
		OP_EMIT_ADV
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic set_end;    // current input beat closes the set
		logic a_zero;     // build loop finished
		logic a_lt2;      // extraction loop finished
		logic sift_done;  // current sift level found its place
		logic emit_last;  // record being emitted is the final one
	} stat_t;

endpackage

### design/hsd_ctrl.sv
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer of the sorter: load, heap build, extraction and emission phases.
// Drives the handshake ready/valid and issues one datapath op per cycle.
// ----------------------------------------------------------------------------
module hsd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  hsd_pkg::stat_t stat,
	output hsd_pkg::cmd_t  cmd
);
	import hsd_pkg::*;

	st_t  state_q, state_d;
	logic build_q, build_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			build_q <= build_d;
		end
	end

	// next state and ops
	always_comb begin
		state_d   = state_q;
		build_d   = build_q;
		cmd.op    = OP_IDLE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					if (stat.set_end) begin
						build_d = 1'b1;
						state_d = S_BUILD_NEXT;
					end
				end
			end
			S_BUILD_NEXT: begin
				if (stat.a_zero) begin
					cmd.op  = OP_EXT_INIT;
					build_d = 1'b0;
					state_d = S_EXT_NEXT;
				end else begin
					state_d = S_BUILD_RD;
				end
			end
			S_BUILD_RD: begin
				cmd.op  = OP_BUILD_RD;
				state_d = S_BUILD_LD;
			end
			S_BUILD_LD: begin
				cmd.op  = OP_BUILD_LD;
				state_d = S_SIFT_RD;
			end
			S_EXT_NEXT: begin
				if (stat.a_lt2) begin
					cmd.op  = OP_EMIT_INIT;
					state_d = S_EMIT_RD;
				end else begin
					state_d = S_EXT_RD;
				end
			end
			S_EXT_RD: begin
				cmd.op  = OP_EXT_RD;
				state_d = S_EXT_LD;
			end
			S_EXT_LD: begin
				cmd.op  = OP_EXT_LD;
				state_d = S_SIFT_RD;
			end
			S_SIFT_RD: begin
				cmd.op  = OP_SIFT_RD;
				state_d = S_SIFT_CMP;
			end
			S_SIFT_CMP: begin
				cmd.op = OP_SIFT_CMP;
				if (stat.sift_done) begin
					state_d = build_q ? S_BUILD_NEXT : S_EXT_NEXT;
				end else begin
					state_d = S_SIFT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.op  = OP_EMIT_LD;
				state_d = S_EMIT_HOLD;
			end
			S_EMIT_HOLD: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.emit_last) begin
						state_d = S_LOAD;
					end else begin
						cmd.op  = OP_EMIT_ADV;
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// input and output sides never open together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid both high");

	// build phase flag only set while heap build is running
	a_build_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXT_RD || state_q == S_EXT_LD) |-> !build_q)
		else $error("extraction step while build flag set");

	// a finished set always leads into the heap build
	a_set_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && in_valid && stat.set_end) |=> state_q == S_BUILD_NEXT)
		else $error("set end did not start the sort");

endmodule

### design/hsd_datapath.sv
// ----------------------------------------------------------------------------
// hsd_datapath
// Record memory with one write and two registered read ports, the sift
// element register, loop counters and the output register.
// ----------------------------------------------------------------------------
module hsd_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hsd_pkg::cmd_t              cmd,
	output hsd_pkg::stat_t             stat,
	input  logic [hsd_pkg::KEY_W-1:0]  sort_key,
	input  logic [hsd_pkg::TAG_W-1:0]  record_tag,
	input  logic                       last_item,
	output logic [hsd_pkg::KEY_W-1:0]  out_key,
	output logic [hsd_pkg::TAG_W-1:0]  out_tag,
	output logic                       out_last
);
	import hsd_pkg::*;

	rec_t             mem_q [DEPTH];
	rec_t             rd_a_q, rd_b_q;
	rec_t             x_q;
	logic [CNT_W-1:0] count_q, n_q, a_q, len_q;
	logic [IDX_W-1:0] i_q, k_q;
	logic [KEY_W-1:0] okey_q;
	logic [TAG_W-1:0] otag_q;
	logic             olast_q;

	logic [CNT_W-1:0] count_inc, am1, l_idx;
	logic [CNT_W:0]   r_idx;
	logic             l_ok, r_ok, pick_l, pick_r;
	logic [KEY_W-1:0] small_key;
	rec_t             child;
	logic [IDX_W-1:0] child_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
	rec_t             wr_data, in_rec;

	assign in_rec    = '{key: sort_key, tag: record_tag};
	assign count_inc = count_q + CNT_W'(1);
	assign am1       = a_q - CNT_W'(1);

	// children of the sift node and the smaller-child pick
	assign l_idx     = {i_q, 1'b1};
	assign r_idx     = {1'b0, i_q, 1'b1} + (CNT_W+1)'(1);
	assign l_ok      = l_idx < len_q;
	assign r_ok      = r_idx < {1'b0, len_q};
	assign pick_l    = l_ok && (rd_a_q.key < x_q.key);
	assign small_key = pick_l ? rd_a_q.key : x_q.key;
	assign pick_r    = r_ok && (rd_b_q.key < small_key);
	assign child     = pick_r ? rd_b_q : rd_a_q;
	assign child_idx = pick_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];

	// status to the controller
	assign stat.set_end   = last_item || (count_q == CNT_W'(DEPTH - 1));
	assign stat.a_zero    = (a_q == '0);
	assign stat.a_lt2     = (a_q < CNT_W'(2));
	assign stat.sift_done = !pick_l && !pick_r;
	assign stat.emit_last = ({1'b0, k_q} + CNT_W'(1)) == n_q;

	// memory address and write selection
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = count_q[IDX_W-1:0];
		wr_data   = in_rec;
		rd_addr_a = k_q;
		rd_addr_b = am1[IDX_W-1:0];
		case (cmd.op)
			OP_LOAD: begin
				wr_en = 1'b1;
			end
			OP_EXT_LD: begin
				wr_en   = 1'b1;
				wr_addr = am1[IDX_W-1:0];
				wr_data = rd_a_q;
			end
			OP_SIFT_CMP: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = stat.sift_done ? x_q : child;
			end
			OP_BUILD_RD: begin
				rd_addr_a = am1[IDX_W-1:0];
			end
			OP_EXT_RD: begin
				rd_addr_a = '0;
			end
			OP_SIFT_RD: begin
				rd_addr_a = l_idx[IDX_W-1:0];
				rd_addr_b = r_idx[IDX_W-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// record memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	// counters and loop indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			n_q     <= '0;
			a_q     <= '0;
			len_q   <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					if (stat.set_end) begin
						n_q     <= count_inc;
						a_q     <= count_inc >> 1;
						count_q <= '0;
					end else begin
						count_q <= count_inc;
					end
				end
				OP_EXT_INIT:  a_q <= n_q;
				OP_EMIT_INIT: k_q <= '0;
				OP_BUILD_LD: begin
					i_q   <= am1[IDX_W-1:0];
					len_q <= n_q;
				end
				OP_EXT_LD: begin
					i_q   <= '0;
					len_q <= am1;
				end
				OP_SIFT_CMP: begin
					if (stat.sift_done) begin
						a_q <= am1;
					end else begin
						i_q <= child_idx;
					end
				end
				OP_EMIT_ADV: k_q <= k_q + IDX_W'(1);
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// sift element and output register
	always_ff @(posedge clk) begin
		if (cmd.op == OP_BUILD_LD) begin
			x_q <= rd_a_q;
		end else if (cmd.op == OP_EXT_LD) begin
			x_q <= rd_b_q;
		end
		if (cmd.op == OP_EMIT_LD) begin
			okey_q  <= rd_a_q.key;
			otag_q  <= rd_a_q.tag;
			olast_q <= stat.emit_last;
		end
	end

	assign out_key  = okey_q;
	assign out_tag  = otag_q;
	assign out_last = olast_q;

	// sift node stays inside the active heap
	a_sift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SIFT_CMP) |-> ({1'b0, i_q} < len_q))
		else $error("sift node outside heap");

	// fill count never reaches the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(DEPTH))
		else $error("record count overflow");

	// loop bound never exceeds the set size
	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SIFT_CMP || cmd.op == OP_EXT_LD) |-> (a_q <= n_q))
		else $error("loop index above set size");

endmodule

### design/heap_sort_descending.sv
// ----------------------------------------------------------------------------
// heap_sort_descending
// Heapsort record sorter: loads up to 64 key/tag records, sorts them with an
// in-place min-heap and emits them in descending key order.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid/in_ready) takes one record beat per cycle while
//    loading: sort_key, record_tag and last_item
//  - a beat with last_item set, or the 64th beat, closes the set and starts
//    the sort; in_ready stays low until the last result beat is taken
//  - output channel (out_valid/out_ready) then delivers all n records, largest
//    key first, out_last high on the final beat
//  - sort time: every heap build node and every extraction step passes its
//    next, read and load states, then a read and a compare state per sift
//    level (one dual-port read of both children, one compare and write);
//    the sort time of a full set of 64 is set by the serial sift steps
//  - emission passes the read, load and hold states for each record, so the
//    first result beat follows the sort after its read and load states
//  - a stalled receiver holds the output register and the sequencer in place
//  - reset clears the counters and returns to loading; memory contents are
//    not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module heap_sort_descending (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hsd_pkg::KEY_W-1:0]  sort_key,
	input  logic [hsd_pkg::TAG_W-1:0]  record_tag,
	input  logic                       last_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [hsd_pkg::KEY_W-1:0]  out_key,
	output logic [hsd_pkg::TAG_W-1:0]  out_tag,
	output logic                       out_last
);
	import hsd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	hsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// record memory and datapath
	hsd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.sort_key   (sort_key),
		.record_tag (record_tag),
		.last_item  (last_item),
		.out_key    (out_key),
		.out_tag    (out_tag),
		.out_last   (out_last)
	);

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heapsort record sorter. A directed table covers
// single-record sets, extreme keys, ties and short sets. Random sets follow,
// including full sets with and without the last mark. Every accepted record
// goes into a local min-heap sort, and each output beat is checked against the
// oldest sorted record still waiting. Input gaps and output stalls vary by
// phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;
	import hsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 80;
	localparam int DIR_N       = 25;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
	} sorted_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic             last;
		logic             typed;
		sorted_beat_t     want;
	} dir_row_t;

	typedef enum int {
		KM_FULL,
		KM_NOMINAL,
		KM_TIES,
		KM_EXTREME
	} key_mode_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [KEY_W-1:0] sort_key;
	logic [TAG_W-1:0] record_tag;
	logic             last_item;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [KEY_W-1:0] out_key;
	logic [TAG_W-1:0] out_tag;
	logic             out_last;

	// records of the set being loaded, sorted in place when it closes
	rec_t         set_recs [DEPTH];
	int           set_len;
	sorted_beat_t sorted_fifo [$];

	int errors;
	int items_sent;
	int idle_pct;
	int stall_pct;
	int hold_pulses;
	int hold_seen;
	int hold_left;
	int cycles;

	// directed stimulus: typed results only for single-record sets
	dir_row_t directed_rows [DIR_N] = '{
		'{14'd10000, 32'hFFFF_FFFF, 1'b1, 1'b1, '{14'd10000, 32'hFFFF_FFFF, 1'b1}},
		'{14'd0,     32'h0000_0000, 1'b1, 1'b1, '{14'd0,     32'h0000_0000, 1'b1}},
		'{14'd16383, 32'h0000_0001, 1'b1, 1'b1, '{14'd16383, 32'h0000_0001, 1'b1}},
		'{14'd1,     32'h8000_0000, 1'b1, 1'b1, '{14'd1,     32'h8000_0000, 1'b1}},
		'{14'd5000,  32'h0000_0011, 1'b0, 1'b0, '0},
		'{14'd5000,  32'h0000_0022, 1'b1, 1'b0, '0},
		'{14'd0,     32'h0000_0033, 1'b0, 1'b0, '0},
		'{14'd10000, 32'h0000_0044, 1'b1, 1'b0, '0},
		'{14'd3000,  32'hA1A1_A1A1, 1'b0, 1'b0, '0},
		'{14'd10000, 32'hA2A2_A2A2, 1'b0, 1'b0, '0},
		'{14'd0,     32'hA3A3_A3A3, 1'b0, 1'b0, '0},
		'{14'd3000,  32'hA4A4_A4A4, 1'b0, 1'b0, '0},
		'{14'd16383, 32'hA5A5_A5A5, 1'b0, 1'b0, '0},
		'{14'd9999,  32'hA6A6_A6A6, 1'b0, 1'b0, '0},
		'{14'd3000,  32'hA7A7_A7A7, 1'b0, 1'b0, '0},
		'{14'd1,     32'hA8A8_A8A8, 1'b1, 1'b0, '0},
		'{14'd7777,  32'h5555_5555, 1'b0, 1'b0, '0},
		'{14'd7777,  32'hAAAA_AAAA, 1'b0, 1'b0, '0},
		'{14'd7777,  32'hB3B3_B3B3, 1'b0, 1'b0, '0},
		'{14'd7777,  32'hB4B4_B4B4, 1'b0, 1'b0, '0},
		'{14'd7777,  32'hB5B5_B5B5, 1'b0, 1'b0, '0},
		'{14'd7777,  32'hB6B6_B6B6, 1'b0, 1'b0, '0},
		'{14'd7777,  32'hB7B7_B7B7, 1'b1, 1'b0, '0},
		'{14'd12,    32'hC1C1_C1C1, 1'b0, 1'b0, '0},
		'{14'd11,    32'hC2C2_C2C2, 1'b1, 1'b0, '0}
	};

	heap_sort_descending u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sort_key   (sort_key),
		.record_tag (record_tag),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_key    (out_key),
		.out_tag    (out_tag),
		.out_last   (out_last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// min-heap sift-down of one node, left child tried first, strict less-than
	function automatic void sift_min(input int len, input int node);
		int   at;
		int   smallest;
		int   lc;
		int   rc;
		bit   settled;
		rec_t t;
		at      = node;
		settled = 1'b0;
		while (!settled) begin
			smallest = at;
			lc       = 2 * at + 1;
			rc       = 2 * at + 2;
			if (lc < len && set_recs[lc].key < set_recs[smallest].key)
				smallest = lc;
			if (rc < len && set_recs[rc].key < set_recs[smallest].key)
				smallest = rc;
			if (smallest == at) begin
				settled = 1'b1;
			end else begin
				t                  = set_recs[at];
				set_recs[at]       = set_recs[smallest];
				set_recs[smallest] = t;
				at                 = smallest;
			end
		end
	endfunction

	// heap build then root extraction to the tail: leaves keys descending
	function automatic void heapsort_set(input int n);
		rec_t t;
		for (int a = n / 2 - 1; a >= 0; a--)
			sift_min(n, a);
		for (int a = n - 1; a >= 0; a--) begin
			t           = set_recs[0];
			set_recs[0] = set_recs[a];
			set_recs[a] = t;
			sift_min(a, 0);
		end
	endfunction

	// take one accepted record; a closed set queues its sorted beats
	function automatic void load_record(input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic last, input bit typed,
			input sorted_beat_t want);
		sorted_beat_t beat;
		set_recs[set_len].key = key;
		set_recs[set_len].tag = tag;
		set_len++;
		if (last || set_len == DEPTH) begin
			heapsort_set(set_len);
			for (int k = 0; k < set_len; k++) begin
				beat.key  = set_recs[k].key;
				beat.tag  = set_recs[k].tag;
				beat.last = (k == set_len - 1);
				sorted_fifo.push_back(typed ? want : beat);
			end
			set_len = 0;
		end
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(input key_mode_t mode);
		logic [KEY_W-1:0] key;
		case (mode)
			KM_FULL:    key = KEY_W'($urandom_range(16383));
			KM_NOMINAL: key = KEY_W'($urandom_range(10000));
			KM_TIES:    key = KEY_W'($urandom_range(3) * 2500);
			default: begin
				case ($urandom_range(3))
					0:       key = 14'd0;
					1:       key = 14'd10000;
					2:       key = 14'd16383;
					default: key = 14'd1;
				endcase
			end
		endcase
		return key;
	endfunction

	// offer one record beat after a random gap, hold it until accepted
	task automatic send_beat(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
			input logic last, input bit typed, input sorted_beat_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		sort_key   <= key;
		record_tag <= tag;
		last_item  <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		load_record(key, tag, last, typed, want);
		items_sent++;
	endtask

	// sender stops until every sorted record has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sorted_fifo.size() != 0);
	endtask

	task automatic send_random_set(input int size, input bit mark_last, input key_mode_t mode);
		for (int i = 0; i < size; i++)
			send_beat(pick_key(mode), $urandom, mark_last && (i == size - 1), 1'b0, '0);
	endtask

	// one idling phase of random sets, optionally opened by a full set
	task automatic run_phase(input int idle, input int stall, input bit lead_full,
			input bit full_mark);
		int start;
		int size;
		bit mark;
		idle_pct  = idle;
		stall_pct = stall;
		start     = items_sent;
		if (lead_full)
			send_random_set(DEPTH, full_mark, KM_FULL);
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(29) == 0) begin
				size = DEPTH;
				mark = 1'($urandom_range(1));
			end else begin
				size = $urandom_range(12, 1);
				mark = 1'b1;
			end
			send_random_set(size, mark, key_mode_t'($urandom_range(3)));
			if ($urandom_range(9) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// compare one output beat with the oldest sorted record
	task automatic check_beat();
		sorted_beat_t want;
		if (sorted_fifo.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("unexpected beat: key %0d tag %h last %0b",
					out_key, out_tag, out_last);
		end else begin
			want = sorted_fifo.pop_front();
			if (out_key !== want.key || out_tag !== want.tag || out_last !== want.last) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("mismatch: expected key %0d tag %h last %0b, got key %0d tag %h last %0b",
						want.key, want.tag, want.last, out_key, out_tag, out_last);
			end
		end
	endtask

	// output side: check taken beats, then random stalls or a long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_beat();
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_pulses != hold_seen) begin
			hold_seen = hold_pulses;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sort_key   = '0;
		record_tag = '0;
		last_item  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		for (int r = 0; r < DIR_N; r++)
			send_beat(directed_rows[r].key, directed_rows[r].tag, directed_rows[r].last,
				directed_rows[r].typed, directed_rows[r].want);
		wait_drained();

		// random phases: full set without the last mark first, then one with it
		run_phase(0, 0, 1'b1, 1'b0);
		run_phase(75, 0, 1'b0, 1'b0);
		run_phase(0, 75, 1'b1, 1'b1);
		run_phase(30, 30, 1'b0, 1'b0);

		// long output hold-off while the sender keeps offering sets
		idle_pct  = 0;
		stall_pct = 0;
		hold_pulses <= hold_pulses + 1;
		for (int s = 0; s < 3; s++)
			send_random_set(6, 1'b1, KM_TIES);
		wait_drained();

		repeat (50) @(posedge clk);
		if (errors == 0 && sorted_fifo.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
